// ===== hdl/pgdr_pkg.sv =====
// Shared constants, codes and register map of the presence-gated duty regulator.
package pgdr_pkg;

	localparam int RANGE_W = 13;
	localparam int LIGHT_W = 13;
	localparam int DIST_W  = 14;
	localparam int DUTY_W  = 7;
	localparam int CNT_W   = 8;
	localparam int MV_W    = 12;
	localparam int OP_W    = 2;
	localparam int LSTAT_W = 2;

	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int REG_IDX_W = 3;

	// event codes
	localparam logic [OP_W-1:0] OP_RANGE = 2'd0;
	localparam logic [OP_W-1:0] OP_LIGHT = 2'd1;
	localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

	// light status codes
	localparam logic [LSTAT_W-1:0] LS_IN_BAND = 2'd0;
	localparam logic [LSTAT_W-1:0] LS_ABOVE   = 2'd1;
	localparam logic [LSTAT_W-1:0] LS_BELOW   = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_ACTIVATE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_RELEASE    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_REL_LIMIT  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BAD_LIMIT  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LIGHT_TGT  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LIGHT_BAND = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_DUTY_STEP  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_START_DUTY = 3'd7;

	// register reset values
	localparam logic [RANGE_W-1:0] ACTIVATE_RST   = 13'd150;
	localparam logic [RANGE_W-1:0] RELEASE_RST    = 13'd150;
	localparam logic [CNT_W-1:0]   REL_LIMIT_RST  = 8'd10;
	localparam logic [CNT_W-1:0]   BAD_LIMIT_RST  = 8'd20;
	localparam logic [MV_W-1:0]    LIGHT_TGT_RST  = 12'd2000;
	localparam logic [MV_W-1:0]    LIGHT_BAND_RST = 12'd100;
	localparam logic [DUTY_W-1:0]  DUTY_STEP_RST  = 7'd2;
	localparam logic [DUTY_W-1:0]  START_DUTY_RST = 7'd50;

	localparam logic [RANGE_W-1:0] BAD_RANGE_MM = 13'd8190;
	localparam logic [DUTY_W-1:0]  DUTY_MAX     = 7'd100;
	localparam logic [CNT_W-1:0]   CNT_SAT      = 8'hFF;
	localparam logic signed [DIST_W-1:0] DIST_NONE = -14'sd1;

endpackage

// ===== hdl/presence_gated_duty_regulator.sv =====
// Presence-gated LED duty regulator: event register, state update and result register.
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+-------------------------------------
//  event     | in        | event_valid / event_stall   | op, object_found, range_mm, light_mv
//  result    | out       | result_valid / result_stall | running, duty_percent, distance_mm,
//            |           |                             | reinit_request, started, stopped,
//            |           |                             | light_status
//  config    | in        | APB write/read              | eight registers at 4*index
//
// One event per cycle while the result side does not stall: an accepted event sits in the
// event register, the state update is worked out from it there and lands in the state and result
// registers together, so the next event sees the updated state straight away.
// A transferred event passes through the event register and then the result register to result valid.
// A stalled result holds the event register; the event side stalls only when both are full.
// arst_n resets control state, the state variables and the configuration registers to their reset values.
module presence_gated_duty_regulator (
	input  logic                               clk,
	input  logic                               arst_n,
	// event channel
	input  logic                               event_valid,
	output logic                               event_stall,
	input  logic [pgdr_pkg::OP_W-1:0]          op,
	input  logic                               object_found,
	input  logic [pgdr_pkg::RANGE_W-1:0]       range_mm,
	input  logic signed [pgdr_pkg::LIGHT_W-1:0] light_mv,
	// result channel
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               running,
	output logic [pgdr_pkg::DUTY_W-1:0]        duty_percent,
	output logic signed [pgdr_pkg::DIST_W-1:0] distance_mm,
	output logic                               reinit_request,
	output logic                               started,
	output logic                               stopped,
	output logic [pgdr_pkg::LSTAT_W-1:0]       light_status,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pgdr_pkg::ADDR_W-1:0]        paddr,
	input  logic [pgdr_pkg::DATA_W-1:0]        pwdata,
	output logic [pgdr_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import pgdr_pkg::*;

	// configuration registers
	logic [RANGE_W-1:0] activate_q;
	logic [RANGE_W-1:0] release_q;
	logic [CNT_W-1:0]   rel_limit_q;
	logic [CNT_W-1:0]   bad_limit_q;
	logic [MV_W-1:0]    light_tgt_q;
	logic [MV_W-1:0]    light_band_q;
	logic [DUTY_W-1:0]  duty_step_q;
	logic [DUTY_W-1:0]  start_duty_q;

	logic                 cfg_write;
	logic [REG_IDX_W-1:0] reg_idx;

	// event register
	logic                       valid_s1;
	logic [OP_W-1:0]            op_s1;
	logic                       found_s1;
	logic [RANGE_W-1:0]         range_s1;
	logic signed [LIGHT_W-1:0]  light_s1;

	// regulator state
	logic                       active_q;
	logic [CNT_W-1:0]           bad_q;
	logic [CNT_W-1:0]           far_q;
	logic signed [DIST_W-1:0]   dist_q;
	logic [DUTY_W-1:0]          duty_q;

	// result register
	logic                       valid_s2;
	logic                       running_s2;
	logic [DUTY_W-1:0]          duty_s2;
	logic signed [DIST_W-1:0]   dist_s2;
	logic                       reinit_s2;
	logic                       started_s2;
	logic                       stopped_s2;
	logic [LSTAT_W-1:0]         lstat_s2;

	// next state
	logic                       active_d;
	logic [CNT_W-1:0]           bad_d;
	logic [CNT_W-1:0]           far_d;
	logic signed [DIST_W-1:0]   dist_d;
	logic [DUTY_W-1:0]          duty_d;
	logic                       reinit_d;
	logic                       started_d;
	logic                       stopped_d;
	logic [LSTAT_W-1:0]         lstat_d;

	// datapath helpers
	logic                       advance;
	logic                       reading_bad;
	logic [CNT_W-1:0]           bad_inc;
	logic [CNT_W-1:0]           far_inc;
	logic signed [DIST_W-1:0]   dist_new;
	logic                       near_hit;
	logic                       far_hit;
	logic [DUTY_W-1:0]          start_duty;
	logic signed [DIST_W:0]     light_err;
	logic signed [DIST_W:0]     band_ext;
	logic signed [DIST_W:0]     err_plus_band;
	logic [DUTY_W:0]            duty_sum;
	logic [DUTY_W-1:0]          duty_dn;
	logic [DUTY_W-1:0]          duty_up;

	//------------------------------------------------------------------
	// Configuration port: always ready, write on the access phase.
	//------------------------------------------------------------------
	assign pready    = 1'b1;
	assign reg_idx   = paddr[ADDR_W-1:2];
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			activate_q   <= ACTIVATE_RST;
			release_q    <= RELEASE_RST;
			rel_limit_q  <= REL_LIMIT_RST;
			bad_limit_q  <= BAD_LIMIT_RST;
			light_tgt_q  <= LIGHT_TGT_RST;
			light_band_q <= LIGHT_BAND_RST;
			duty_step_q  <= DUTY_STEP_RST;
			start_duty_q <= START_DUTY_RST;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_ACTIVATE:   activate_q   <= pwdata[RANGE_W-1:0];
				REG_RELEASE:    release_q    <= pwdata[RANGE_W-1:0];
				REG_REL_LIMIT:  rel_limit_q  <= pwdata[CNT_W-1:0];
				REG_BAD_LIMIT:  bad_limit_q  <= pwdata[CNT_W-1:0];
				REG_LIGHT_TGT:  light_tgt_q  <= pwdata[MV_W-1:0];
				REG_LIGHT_BAND: light_band_q <= pwdata[MV_W-1:0];
				REG_DUTY_STEP:  duty_step_q  <= pwdata[DUTY_W-1:0];
				REG_START_DUTY: start_duty_q <= pwdata[DUTY_W-1:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_ACTIVATE:   prdata[RANGE_W-1:0] = activate_q;
			REG_RELEASE:    prdata[RANGE_W-1:0] = release_q;
			REG_REL_LIMIT:  prdata[CNT_W-1:0]   = rel_limit_q;
			REG_BAD_LIMIT:  prdata[CNT_W-1:0]   = bad_limit_q;
			REG_LIGHT_TGT:  prdata[MV_W-1:0]    = light_tgt_q;
			REG_LIGHT_BAND: prdata[MV_W-1:0]    = light_band_q;
			REG_DUTY_STEP:  prdata[DUTY_W-1:0]  = duty_step_q;
			REG_START_DUTY: prdata[DUTY_W-1:0]  = start_duty_q;
		endcase
	end

	//------------------------------------------------------------------
	// Flow control: the event register moves on whenever the result
	// register is empty or its transfer completes this cycle.
	//------------------------------------------------------------------
	assign advance     = !(valid_s2 && result_stall);
	assign event_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!event_stall) begin
			valid_s1 <= event_valid;
		end
	end

	// payload: load on every transfer, hold otherwise
	always_ff @(posedge clk) begin
		if (event_valid && !event_stall) begin
			op_s1    <= op;
			found_s1 <= object_found;
			range_s1 <= range_mm;
			light_s1 <= light_mv;
		end
	end

	//------------------------------------------------------------------
	// State update for the event in the event register.
	//------------------------------------------------------------------
	assign bad_inc  = (bad_q == CNT_SAT) ? bad_q : bad_q + 1'b1;
	assign far_inc  = (far_q == CNT_SAT) ? far_q : far_q + 1'b1;

	// a reading with no object, or at or above the sensor's out-of-range code, is bad
	assign reading_bad = !found_s1 || (range_s1 >= BAD_RANGE_MM);
	assign dist_new    = reading_bad ? DIST_NONE : $signed({1'b0, range_s1});

	// a zero distance is stored but never starts the system
	assign near_hit = (dist_new > 0) && (dist_new < $signed({1'b0, activate_q}));
	assign far_hit  = (dist_new < 0) || (dist_new > $signed({1'b0, release_q}));

	assign start_duty = (start_duty_q > DUTY_MAX) ? DUTY_MAX : start_duty_q;

	// light error against the target, and its sum with the half band for the lower edge
	assign light_err     = $signed({{(DIST_W+1-LIGHT_W){light_s1[LIGHT_W-1]}}, light_s1})
	                     - $signed({{(DIST_W+1-MV_W){1'b0}}, light_tgt_q});
	assign band_ext      = $signed({{(DIST_W+1-MV_W){1'b0}}, light_band_q});
	assign err_plus_band = light_err + band_ext;

	// step down floors at zero, step up clamps at full duty
	assign duty_dn  = (duty_q < duty_step_q) ? '0 : duty_q - duty_step_q;
	assign duty_sum = {1'b0, duty_q} + {1'b0, duty_step_q};
	assign duty_up  = (duty_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX : duty_sum[DUTY_W-1:0];

	always_comb begin
		active_d  = active_q;
		bad_d     = bad_q;
		far_d     = far_q;
		dist_d    = dist_q;
		duty_d    = duty_q;
		reinit_d  = 1'b0;
		started_d = 1'b0;
		stopped_d = 1'b0;
		lstat_d   = LS_IN_BAND;
		unique case (op_s1)
			OP_RANGE: begin
				dist_d = dist_new;
				if (reading_bad) begin
					bad_d = bad_inc;
					// fire the re-initialise pulse and clear the count at the limit
					if (bad_inc >= bad_limit_q) begin
						reinit_d = 1'b1;
						bad_d    = '0;
					end
				end else begin
					bad_d = '0;
				end
				if (!active_q) begin
					if (near_hit) begin
						active_d  = 1'b1;
						far_d     = '0;
						duty_d    = start_duty;
						started_d = 1'b1;
					end
				end else if (far_hit) begin
					far_d = far_inc;
					if (far_inc >= rel_limit_q) begin
						active_d  = 1'b0;
						duty_d    = '0;
						far_d     = '0;
						stopped_d = 1'b1;
					end
				end else begin
					far_d = '0;
				end
			end
			OP_LIGHT: begin
				// status is reported whether running or not; duty moves only while running
				if (light_err > band_ext) begin
					lstat_d = LS_ABOVE;
					if (active_q) begin
						duty_d = duty_dn;
					end
				end else if (err_plus_band < 0) begin
					lstat_d = LS_BELOW;
					if (active_q) begin
						duty_d = duty_up;
					end
				end
			end
			OP_STOP: begin
				// drop to idle; the far count is left as it was
				stopped_d = active_q;
				active_d  = 1'b0;
				duty_d    = '0;
			end
			default: begin
				// unused code: report the current state, change nothing
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			bad_q    <= '0;
			far_q    <= '0;
			dist_q   <= DIST_NONE;
			duty_q   <= '0;
		end else if (valid_s1 && advance) begin
			active_q <= active_d;
			bad_q    <= bad_d;
			far_q    <= far_d;
			dist_q   <= dist_d;
			duty_q   <= duty_d;
		end
	end

	//------------------------------------------------------------------
	// Result register.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			running_s2 <= active_d;
			duty_s2    <= duty_d;
			dist_s2    <= dist_d;
			reinit_s2  <= reinit_d;
			started_s2 <= started_d;
			stopped_s2 <= stopped_d;
			lstat_s2   <= lstat_d;
		end
	end

	assign result_valid   = valid_s2;
	assign running        = running_s2;
	assign duty_percent   = duty_s2;
	assign distance_mm    = dist_s2;
	assign reinit_request = reinit_s2;
	assign started        = started_s2;
	assign stopped        = stopped_s2;
	assign light_status   = lstat_s2;

endmodule
